// File: src/jbp_pkg.sv
// shared types and constants for the jpeg bit packer
// no dependencies; imported by every module of the block
package jbp_pkg;

    localparam int BYTE_W        = 8;
    localparam int CODE_FIELD_W  = 16;
    localparam int COUNT_W       = 5;
    localparam int MAX_CODE_BITS = 16;
    localparam int CODE_LIMIT    = (MAX_CODE_BITS < CODE_FIELD_W) ? MAX_CODE_BITS : CODE_FIELD_W;
    // pending bits plus one full code
    localparam int ACC_W         = CODE_FIELD_W + BYTE_W;
    // bytes per group: up to two raw bytes, each may be followed by a stuffed zero
    localparam int GROUP_BYTES   = 4;
    localparam int GROUP_CNT_W   = 3;
    localparam int GROUP_IDX_W   = 2;

    localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] STUFF_BYTE  = 8'h00;

    typedef enum logic
    {
        REQ_APPEND = 1'b0,
        REQ_FLUSH  = 1'b1
    } req_type_t;

    // bytes produced by one request, in stream order
    typedef struct packed
    {
        logic [GROUP_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [GROUP_CNT_W-1:0]             count;
    } group_t;

endpackage

// File: src/jbp_packer.sv
// request register, bit accumulator and byte stuffing logic
// depends on jbp_pkg; hands byte groups to jbp_serializer
module jbp_packer
    import jbp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [COUNT_W-1:0]      bit_count,
    input  logic [CODE_FIELD_W-1:0] code_bits,
    output logic                    grp_valid,
    input  logic                    grp_ready,
    output group_t                  grp
);

    logic                    item_valid_reg;
    logic                    req_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [CODE_FIELD_W-1:0] code_reg;
    logic [BYTE_W-1:0]       pend_bits_reg;
    logic [BYTE_W-1:0]       pend_bits_next;
    logic [2:0]              pend_cnt_reg;
    logic [2:0]              pend_cnt_next;

    logic                    flush;
    logic                    advance;
    logic [COUNT_W-1:0]      sat_cnt;
    logic [COUNT_W-1:0]      eff_cnt;
    logic [CODE_FIELD_W-1:0] eff_code;
    logic [CODE_FIELD_W:0]   code_mask;
    logic [ACC_W-1:0]        acc;
    logic [ACC_W-1:0]        aligned;
    logic [COUNT_W-1:0]      total;
    logic [1:0]              nbytes;
    logic [BYTE_W-1:0]       raw0;
    logic [BYTE_W-1:0]       raw1;
    logic                    stuff0;
    logic                    stuff1;

    always_comb
    begin
        flush   = (req_reg == REQ_FLUSH);
        sat_cnt = (count_reg > COUNT_W'(CODE_LIMIT)) ? COUNT_W'(CODE_LIMIT) : count_reg;
        // a flush appends ones up to the byte boundary
        if (flush)
        begin
            eff_cnt = (pend_cnt_reg == 3'd0) ? '0 : COUNT_W'(BYTE_W) - {2'b00, pend_cnt_reg};
        end
        else
        begin
            eff_cnt = sat_cnt;
        end
        eff_code  = flush ? '1 : code_reg;
        code_mask = ((CODE_FIELD_W+1)'(1) << eff_cnt) - (CODE_FIELD_W+1)'(1);
        acc       = ({{(ACC_W-BYTE_W){1'b0}}, pend_bits_reg} << eff_cnt)
                  | {{BYTE_W{1'b0}}, eff_code & code_mask[CODE_FIELD_W-1:0]};
        total     = {2'b00, pend_cnt_reg} + eff_cnt;
        nbytes    = total[4:3];
        aligned   = acc << (COUNT_W'(ACC_W) - total);
        raw0      = aligned[ACC_W-1 -: BYTE_W];
        raw1      = aligned[ACC_W-BYTE_W-1 -: BYTE_W];
        stuff0    = (raw0 == MARKER_BYTE);
        stuff1    = (raw1 == MARKER_BYTE);

        pend_bits_next = acc[BYTE_W-1:0] & ((BYTE_W'(1) << total[2:0]) - BYTE_W'(1));
        pend_cnt_next  = total[2:0];

        // stuffed zeros fill every slot not taken by a raw byte
        grp.bytes = {GROUP_BYTES{STUFF_BYTE}};
        grp.count = '0;
        case (nbytes)
            2'd1:
            begin
                grp.bytes[0] = raw0;
                grp.count    = 3'd1 + {2'b00, stuff0};
            end
            2'd2:
            begin
                grp.bytes[0] = raw0;
                if (stuff0)
                begin
                    grp.bytes[2] = raw1;
                end
                else
                begin
                    grp.bytes[1] = raw1;
                end
                grp.count = 3'd2 + {2'b00, stuff0} + {2'b00, stuff1};
            end
            default:
            begin
                grp.count = '0;
            end
        endcase
    end

    // requests with no output leave without waiting on the serializer
    assign grp_valid = item_valid_reg && (grp.count != '0);
    assign advance   = item_valid_reg && ((grp.count == '0) || grp_ready);
    assign in_ready  = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            pend_bits_reg  <= '0;
            pend_cnt_reg   <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                pend_bits_reg <= pend_bits_next;
                pend_cnt_reg  <= pend_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg   <= req_type;
            count_reg <= bit_count;
            code_reg  <= code_bits;
        end
    end

endmodule

// File: src/jbp_serializer.sv
// holds one byte group and sends it out a byte per cycle while out_ready is high
// depends on jbp_pkg; fed by jbp_packer
module jbp_serializer
    import jbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              grp_valid,
    output logic              grp_ready,
    input  group_t            grp,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last
);

    group_t                 grp_reg;
    logic                   grp_valid_reg;
    logic [GROUP_IDX_W-1:0] idx_reg;
    logic                   done;

    assign out_valid = grp_valid_reg;
    assign out_byte  = grp_reg.bytes[idx_reg];
    assign last      = ({1'b0, idx_reg} == (grp_reg.count - 3'd1));
    assign done      = grp_valid_reg && out_ready && last;
    assign grp_ready = !grp_valid_reg || done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (grp_valid && grp_ready)
        begin
            grp_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (done)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (grp_valid_reg && out_ready)
        begin
            idx_reg <= idx_reg + GROUP_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_valid && grp_ready)
        begin
            grp_reg <= grp;
        end
    end

endmodule

// File: src/jpeg_bit_packer_byte_stuffing.sv
// jpeg entropy bit packer with 0xff/0x00 byte stuffing, top level
// depends on jbp_pkg, jbp_packer and jbp_serializer
//
// usage
//   input channel (in_valid/in_ready) takes one request per cycle when ready:
//   an append of bit_count code bits (low bits of code_bits, msb first, count
//   saturates at the code limit) or a flush that pads pending bits with ones
//   output channel (out_valid/out_ready) gives one byte per cycle when ready;
//   every 0xff is followed by a stuffed 0x00, last marks the final byte of
//   the request that produced it; requests that complete no byte give nothing
//   the packer registers a request, then the serializer registers its group
//   throughput: one request per cycle while each makes at most one byte and
//   no output stall; a longer group (up to four bytes with stuffing) holds
//   the serializer until its last byte leaves the single output byte lane
//   reset clears pending bits and empties both stages
//   when the receiver stalls, the byte group waits in the serializer and the
//   packer stage holds the next request, after which in_ready drops
module jpeg_bit_packer_byte_stuffing
    import jbp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [COUNT_W-1:0]      bit_count,
    input  logic [CODE_FIELD_W-1:0] code_bits,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [BYTE_W-1:0]       out_byte,
    output logic                    last
);

    // byte group handed from packer to serializer
    group_t grp;
    logic   grp_valid;
    logic   grp_ready;

    // packs bits and builds the stuffed byte group of each request
    jbp_packer u_packer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .bit_count (bit_count),
        .code_bits (code_bits),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp)
    );

    // sends the group one byte at a time
    jbp_serializer u_serializer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

// File: src/jbp_checker.sv
// port level checks for the jpeg bit packer
// depends on jbp_pkg; bound to jpeg_bit_packer_byte_stuffing
module jbp_checker
    import jbp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic              last
);

    // a stalled byte holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output byte changed while stalled");

    // a marker byte is never the end of a request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_byte == MARKER_BYTE) |-> !last)
        else $error("0xff marked as last byte");

    // a marker byte is followed at once by a stuffed zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (out_byte == MARKER_BYTE)
        |=> out_valid && (out_byte == STUFF_BYTE))
        else $error("missing stuffed zero after 0xff");

endmodule

bind jpeg_bit_packer_byte_stuffing jbp_checker u_jbp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
);
